>>> hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg: shared constants and control word types
// Widths, action codes and the microcode control word of the rc4 core.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  // fixed field widths
  localparam int BYTE_W        = 8;
  localparam int ACT_W         = 2;
  localparam int KLEN_W        = 9;
  localparam int PERM_SIZE     = 256;
  localparam int MAX_KEY_BYTES = 256;
  localparam int STEP_W        = 4;

  localparam logic [KLEN_W-1:0] KEY_LEN_RESET = KLEN_W'(1);

  // item actions
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_DATA    = 2'd2
  } act_e;

  // j register update
  typedef enum logic [1:0] {
    J_HOLD = 2'd0,
    J_CLR  = 2'd1,
    J_KEY  = 2'd2,
    J_DATA = 2'd3
  } jop_e;

  // i register update
  typedef enum logic [1:0] {
    I_HOLD = 2'd0,
    I_CLR  = 2'd1,
    I_INC  = 2'd2
  } iop_e;

  // permutation read address, port a
  typedef enum logic [1:0] {
    RA_INCI = 2'd0,
    RA_P    = 2'd1,
    RA_PINC = 2'd2,
    RA_T    = 2'd3
  } rasel_e;

  // permutation write address
  typedef enum logic [1:0] {
    WA_P = 2'd0,
    WA_I = 2'd1,
    WA_J = 2'd2
  } wasel_e;

  // permutation write data
  typedef enum logic [1:0] {
    WD_P   = 2'd0,
    WD_RDB = 2'd1,
    WD_SI  = 2'd2
  } wdsel_e;

  // sequencer jump conditions
  typedef enum logic [2:0] {
    JC_NEXT     = 3'd0,
    JC_ALWAYS   = 3'd1,
    JC_DISPATCH = 3'd2,
    JC_LOOP     = 3'd3,
    JC_OUTFREE  = 3'd4
  } jcond_e;

  // one microcode control word
  typedef struct packed {
    logic              ready;
    logic              clr_p;
    logic              p_inc;
    logic              kpos_clr;
    logic              kpos_step;
    jop_e              j_op;
    iop_e              i_op;
    logic              si_ld;
    logic              t_ld;
    rasel_e            ra_sel;
    logic              we;
    wasel_e            wa_sel;
    wdsel_e            wd_sel;
    logic              out_ld;
    jcond_e            jc;
    logic [STEP_W-1:0] target;
  } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rc4_chan_if.sv
// ----------------------------------------------------------------------------
// rc4 channel interfaces
// Valid/ready channels for items, results and the key length register.
// ----------------------------------------------------------------------------
`default_nettype none

// input item channel
interface rc4_item_if;
  logic                        valid;
  logic                        ready;
  logic [rc4_pkg::ACT_W-1:0]   action;
  logic [rc4_pkg::BYTE_W-1:0]  key_index;
  logic [rc4_pkg::BYTE_W-1:0]  byte_in;

  modport source (output valid, output action, output key_index, output byte_in,
                  input ready);
  modport sink   (input valid, input action, input key_index, input byte_in,
                  output ready);
endinterface

// result channel
interface rc4_result_if;
  logic                        valid;
  logic                        ready;
  logic [rc4_pkg::BYTE_W-1:0]  byte_out;

  modport source (output valid, output byte_out, input ready);
  modport sink   (input valid, input byte_out, output ready);
endinterface

// key length register write channel
interface rc4_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rc4_pkg::KLEN_W-1:0]  key_length;

  modport source (output valid, output key_length, input ready);
  modport sink   (input valid, input key_length, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rc4_seq.sv
// ----------------------------------------------------------------------------
// rc4_seq: microcode sequencer
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic [rc4_pkg::ACT_W-1:0]   action_i,
  input  wire logic                        p_last_i,
  input  wire logic                        out_free_i,
  output rc4_pkg::ctl_t                    ctl_o
);

  localparam int SW = rc4_pkg::STEP_W;

  // step codes
  localparam logic [SW-1:0] S_IDLE = SW'(0);
  localparam logic [SW-1:0] S_INIT = SW'(1);
  localparam logic [SW-1:0] S_M0   = SW'(2);
  localparam logic [SW-1:0] S_M1   = SW'(3);
  localparam logic [SW-1:0] S_M2   = SW'(4);
  localparam logic [SW-1:0] S_M3   = SW'(5);
  localparam logic [SW-1:0] S_MEND = SW'(6);
  localparam logic [SW-1:0] S_D1   = SW'(7);
  localparam logic [SW-1:0] S_D2   = SW'(8);
  localparam logic [SW-1:0] S_D3   = SW'(9);

  logic [SW-1:0] step_q, step_d;

  // control store
  function automatic rc4_pkg::ctl_t ucode(input logic [SW-1:0] s);
    rc4_pkg::ctl_t c;
    c = '0;
    case (s)
      S_IDLE: begin
        c.ready  = 1'b1;
        c.clr_p  = 1'b1;
        c.ra_sel = rc4_pkg::RA_INCI;
        c.jc     = rc4_pkg::JC_DISPATCH;
      end
      S_INIT: begin
        c.we       = 1'b1;
        c.wa_sel   = rc4_pkg::WA_P;
        c.wd_sel   = rc4_pkg::WD_P;
        c.p_inc    = 1'b1;
        c.kpos_clr = 1'b1;
        c.j_op     = rc4_pkg::J_CLR;
        c.jc       = rc4_pkg::JC_LOOP;
        c.target   = S_INIT;
      end
      S_M0: begin
        c.ra_sel = rc4_pkg::RA_P;
      end
      S_M1: begin
        c.j_op  = rc4_pkg::J_KEY;
        c.si_ld = 1'b1;
      end
      S_M2: begin
        c.we     = 1'b1;
        c.wa_sel = rc4_pkg::WA_P;
        c.wd_sel = rc4_pkg::WD_RDB;
      end
      S_M3: begin
        c.we        = 1'b1;
        c.wa_sel    = rc4_pkg::WA_J;
        c.wd_sel    = rc4_pkg::WD_SI;
        c.p_inc     = 1'b1;
        c.kpos_step = 1'b1;
        c.ra_sel    = rc4_pkg::RA_PINC;
        c.jc        = rc4_pkg::JC_LOOP;
        c.target    = S_M1;
      end
      S_MEND: begin
        c.i_op   = rc4_pkg::I_CLR;
        c.j_op   = rc4_pkg::J_CLR;
        c.jc     = rc4_pkg::JC_ALWAYS;
        c.target = S_IDLE;
      end
      S_D1: begin
        c.i_op  = rc4_pkg::I_INC;
        c.j_op  = rc4_pkg::J_DATA;
        c.si_ld = 1'b1;
      end
      S_D2: begin
        c.we     = 1'b1;
        c.wa_sel = rc4_pkg::WA_I;
        c.wd_sel = rc4_pkg::WD_RDB;
        c.ra_sel = rc4_pkg::RA_T;
        c.t_ld   = 1'b1;
      end
      S_D3: begin
        c.we     = 1'b1;
        c.wa_sel = rc4_pkg::WA_J;
        c.wd_sel = rc4_pkg::WD_SI;
        c.ra_sel = rc4_pkg::RA_T;
        c.out_ld = 1'b1;
        c.jc     = rc4_pkg::JC_OUTFREE;
        c.target = S_IDLE;
      end
      default: begin
        c.jc     = rc4_pkg::JC_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

  assign ctl_o = ucode(step_q);

  // next step
  always_comb begin
    step_d = step_q + SW'(1);
    case (ctl_o.jc)
      rc4_pkg::JC_NEXT:   step_d = step_q + SW'(1);
      rc4_pkg::JC_ALWAYS: step_d = ctl_o.target;
      rc4_pkg::JC_DISPATCH: begin
        step_d = step_q;
        if (fire_i) begin
          case (action_i)
            rc4_pkg::ACT_RESTART: step_d = S_INIT;
            rc4_pkg::ACT_DATA:    step_d = S_D1;
            default:              step_d = step_q;
          endcase
        end
      end
      rc4_pkg::JC_LOOP:    step_d = p_last_i ? step_q + SW'(1) : ctl_o.target;
      rc4_pkg::JC_OUTFREE: step_d = out_free_i ? ctl_o.target : step_q;
      default:             step_d = S_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher: RC4 byte cipher core
// Key store, permutation memory and datapath driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage
//   item_i   : valid/ready items. action load writes byte_in into the key
//              store at key_index; restart runs the key schedule; data
//              returns byte_in xor the next keystream byte on result_o.
//   result_o : one beat per data item, held in an output register.
//   cfg_i    : key_length write channel, always ready; write only while idle.
// Timing
//   load item: ready again the next cycle.
//   data item: steps D1, D2 and D3, where D3 waits for a free output register,
//     then idle again; the next item is taken only after that. One write
//     port, so the swap needs two writes after the read of S[i] and S[j].
//   restart: write the identity, one read to start, then for each of the
//     256 positions a step that forms j and two writes for the swap (single
//     write port), then one step to clear i and j before ready again.
// Reset clears the sequencer, the indices, the output valid and sets
// key_length to 1; the permutation is undefined until the first restart.
// A stalled receiver keeps the result; the next item is still taken, and
// its own result waits in the last step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rc4_item_if.sink         item_i,
  rc4_result_if.source     result_o,
  rc4_cfg_if.sink          cfg_i
);

  localparam int BW     = rc4_pkg::BYTE_W;
  localparam int KLEN_W = rc4_pkg::KLEN_W;
  localparam int KA_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  rc4_pkg::ctl_t ctl;

  logic              fire;
  logic              out_free;
  logic              p_last;

  logic [KLEN_W-1:0] key_length_q;
  logic [KLEN_W-1:0] eff_len;

  logic [BW-1:0]     i_q, i_d;
  logic [BW-1:0]     j_q, j_d;
  logic [BW-1:0]     p_q, p_d;
  logic [KA_W-1:0]   kpos_q, kpos_d;
  logic [KLEN_W-1:0] kpos_inc;

  logic [BW-1:0]     si_q;
  logic [BW-1:0]     t_q;
  logic [BW-1:0]     byte_q;
  logic [BW-1:0]     rda_q, rdb_q, keyrd_q;

  logic [BW-1:0]     ra, rb, wa, wd;
  logic              key_we;

  logic              out_valid_q;
  logic [BW-1:0]     out_byte_q;
  logic [BW-1:0]     ks;

  logic [BW-1:0]     perm_mem [rc4_pkg::PERM_SIZE];
  logic [BW-1:0]     key_mem  [MAX_KEY_BYTES];

  // handshakes
  assign fire           = item_i.valid & item_i.ready;
  assign item_i.ready   = ctl.ready;
  assign cfg_i.ready    = 1'b1;
  assign out_free       = ~out_valid_q | result_o.ready;
  assign result_o.valid = out_valid_q;
  assign result_o.byte_out = out_byte_q;
  assign p_last         = (p_q == '1);

  // sequencer
  rc4_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .action_i   (item_i.action),
    .p_last_i   (p_last),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  // key length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_i.valid) begin
      key_length_q <= cfg_i.key_length;
    end
  end

  // effective key period, zero reads as one, saturates at store depth
  always_comb begin
    if (key_length_q == '0) begin
      eff_len = KLEN_W'(1);
    end else if (key_length_q > KLEN_W'(MAX_KEY_BYTES)) begin
      eff_len = KLEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_length_q;
    end
  end

  // index and counter updates
  assign kpos_inc = KLEN_W'(kpos_q) + KLEN_W'(1);

  always_comb begin
    kpos_d = kpos_q;
    if (ctl.kpos_clr) begin
      kpos_d = '0;
    end else if (ctl.kpos_step) begin
      kpos_d = (kpos_inc == eff_len) ? '0 : kpos_inc[KA_W-1:0];
    end
  end

  always_comb begin
    p_d = p_q;
    if (ctl.clr_p) begin
      p_d = '0;
    end else if (ctl.p_inc) begin
      p_d = p_q + BW'(1);
    end
  end

  always_comb begin
    case (ctl.j_op)
      rc4_pkg::J_HOLD: j_d = j_q;
      rc4_pkg::J_CLR:  j_d = '0;
      rc4_pkg::J_KEY:  j_d = j_q + rda_q + keyrd_q;
      rc4_pkg::J_DATA: j_d = j_q + rda_q;
      default:         j_d = j_q;
    endcase
  end

  always_comb begin
    case (ctl.i_op)
      rc4_pkg::I_HOLD: i_d = i_q;
      rc4_pkg::I_CLR:  i_d = '0;
      rc4_pkg::I_INC:  i_d = i_q + BW'(1);
      default:         i_d = i_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      p_q    <= '0;
      kpos_q <= '0;
    end else begin
      i_q    <= i_d;
      j_q    <= j_d;
      p_q    <= p_d;
      kpos_q <= kpos_d;
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    if (ctl.si_ld) begin
      si_q <= rda_q;
    end
    if (ctl.t_ld) begin
      t_q <= si_q + rdb_q;
    end
    if (fire) begin
      byte_q <= item_i.byte_in;
    end
  end

  // permutation addresses and write data
  // t is formed from the read data in its first step, then held in t_q
  always_comb begin
    case (ctl.ra_sel)
      rc4_pkg::RA_INCI: ra = i_q + BW'(1);
      rc4_pkg::RA_P:    ra = p_q;
      rc4_pkg::RA_PINC: ra = p_q + BW'(1);
      rc4_pkg::RA_T:    ra = ctl.t_ld ? (si_q + rdb_q) : t_q;
      default:          ra = p_q;
    endcase
  end

  assign rb = j_d;

  always_comb begin
    case (ctl.wa_sel)
      rc4_pkg::WA_P: wa = p_q;
      rc4_pkg::WA_I: wa = i_q;
      rc4_pkg::WA_J: wa = j_q;
      default:       wa = p_q;
    endcase
  end

  always_comb begin
    case (ctl.wd_sel)
      rc4_pkg::WD_P:   wd = p_q;
      rc4_pkg::WD_RDB: wd = rdb_q;
      rc4_pkg::WD_SI:  wd = si_q;
      default:         wd = p_q;
    endcase
  end

  // permutation memory, one write and two reads, write-first on reads
  always_ff @(posedge clk_i) begin
    if (ctl.we) begin
      perm_mem[wa] <= wd;
    end
    rda_q <= (ctl.we && (wa == ra)) ? wd : perm_mem[ra];
    rdb_q <= (ctl.we && (wa == rb)) ? wd : perm_mem[rb];
  end

  // key store, written by load beats, read every cycle at the next position
  assign key_we = fire && (item_i.action == rc4_pkg::ACT_LOAD) &&
                  ({1'b0, item_i.key_index} < KLEN_W'(MAX_KEY_BYTES));

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[item_i.key_index[KA_W-1:0]] <= item_i.byte_in;
    end
    keyrd_q <= key_mem[kpos_d];
  end

  // keystream byte, S[j] write still pending when t hits j
  assign ks = (t_q == j_q) ? si_q : rda_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_ld && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_ld && out_free) begin
      out_byte_q <= byte_q ^ ks;
    end
  end

  // checks
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item_i.action == rc4_pkg::ACT_DATA) |=> !item_i.ready)
    else $error("data beat accepted but core still ready");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item_i.action == rc4_pkg::ACT_LOAD) |=> item_i.ready)
    else $error("key load beat left core busy");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ready |-> !ctl.we)
    else $error("permutation written while idle");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.out_ld))
    else $error("result valid without a load step");

endmodule

`default_nettype wire

>>> test/rc4_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_checker: keystream predictor and result scoreboard
// Watches the item, result and key length channels, keeps its own copy of
// the key store, permutation and indices, and compares every result beat
// with the oldest predicted cipher byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rc4_item_if         item_i,
  rc4_result_if       result_i,
  rc4_cfg_if          cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);
  import rc4_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // predicted state of the core
  logic [BYTE_W-1:0] sbox [PERM_SIZE];
  logic [BYTE_W-1:0] key_mem [MAX_KEY_BYTES];
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [KLEN_W-1:0] key_len;

  // cipher bytes still owed by the core, oldest first
  logic [BYTE_W-1:0] expected_bytes [$];
  logic [BYTE_W-1:0] want_byte;

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

  // zero and oversized lengths are clamped into the key store
  function automatic int unsigned key_period(logic [KLEN_W-1:0] len);
    if (len == '0) return 1;
    if (int'(len) > MAX_KEY_BYTES) return MAX_KEY_BYTES;
    return int'(len);
  endfunction

  // identity fill, then 256 key-mixing swaps
  function automatic void schedule_key();
    int unsigned       period;
    logic [BYTE_W-1:0] jj;
    logic [BYTE_W-1:0] tmp;
    period = key_period(key_len);
    jj     = '0;
    for (int p = 0; p < PERM_SIZE; p++) sbox[p] = BYTE_W'(p);
    for (int p = 0; p < PERM_SIZE; p++) begin
      jj       = jj + sbox[p] + key_mem[p % period];
      tmp      = sbox[p];
      sbox[p]  = sbox[jj];
      sbox[jj] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // one generator step, returns the keystream byte
  function automatic logic [BYTE_W-1:0] next_keystream_byte();
    logic [BYTE_W-1:0] tmp;
    logic [BYTE_W-1:0] sum;
    idx_i       = idx_i + 1'b1;
    idx_j       = idx_j + sbox[idx_i];
    tmp         = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    sum         = sbox[idx_i] + sbox[idx_j];
    return sbox[sum];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_i   <= '0;
      idx_j   <= '0;
      key_len <= KEY_LEN_RESET;
      expected_bytes.delete();
      pending_count_o = 0;
    end else begin
      // result beat against the oldest prediction
      if (result_i.valid && result_i.ready) begin
        if (expected_bytes.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: byte_out actual %02h",
                     $realtime, result_i.byte_out);
          mismatch_count_o++;
        end else begin
          want_byte = expected_bytes.pop_front();
          if (result_i.byte_out !== want_byte) begin
            if (mismatch_count_o < REPORT_LIMIT)
              $display("%0t: byte_out mismatch: expected %02h actual %02h",
                       $realtime, want_byte, result_i.byte_out);
            mismatch_count_o++;
          end
        end
      end

      // key length write
      if (cfg_i.valid && cfg_i.ready) key_len = cfg_i.key_length;

      // item beat
      if (item_i.valid && item_i.ready) begin
        case (item_i.action)
          ACT_LOAD:    key_mem[item_i.key_index] = item_i.byte_in;
          ACT_RESTART: schedule_key();
          ACT_DATA:    expected_bytes.push_back(item_i.byte_in ^ next_keystream_byte());
          default:     ;
        endcase
      end

      pending_count_o = expected_bytes.size();
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level testbench of rc4_stream_cipher
// Drives key loads, restarts, data and unused-action beats under changing
// key lengths and idling patterns, including one long receiver hold-off;
// the checker predicts every cipher byte and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import rc4_pkg::*;

  localparam realtime CLK_PERIOD   = 10.0;
  localparam int      RESET_CYCLES = 10;
  localparam int      CYCLE_LIMIT  = 2000000;
  localparam int      RESTART_WAIT = 1200;
  localparam int      HOLD_CYCLES  = 300;
  localparam int      NUM_PHASES   = 8;
  localparam int      PHASE_ITEMS  = 100;
  localparam int      HOLD_PHASE   = 4;

  localparam logic [ACT_W-1:0]  ACT_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] EDGE_BYTES [5] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80};

  typedef enum int {
    IDLE_NONE     = 0,
    IDLE_SENDER   = 1,
    IDLE_RECEIVER = 2,
    IDLE_BOTH     = 3
  } idle_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending_count;

  int unsigned       src_idle_pct;
  int unsigned       sink_stall_pct;
  logic              hold_request;
  logic              hold_active;
  int unsigned       hold_count;
  int unsigned       cycle_count;
  logic [KLEN_W-1:0] cur_key_len;
  bit                key_written [MAX_KEY_BYTES];

  rc4_item_if   item_bus ();
  rc4_result_if result_bus ();
  rc4_cfg_if    cfg_bus ();

  rc4_stream_cipher i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  rc4_stream_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_bus),
    .result_i         (result_bus),
    .cfg_i            (cfg_bus),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // result sink: random stalls, forced low during the hold-off
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_bus.ready = hold_active ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // one long receiver hold-off so the core backs up into the item channel
  initial begin
    hold_active = 1'b0;
    hold_count  = 0;
    wait (hold_request === 1'b1);
    @(posedge clk_i);
    hold_active = 1'b1;
    while (hold_count < HOLD_CYCLES) begin
      @(posedge clk_i);
      hold_count++;
    end
    hold_active = 1'b0;
  end

  function automatic void set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 76; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 76; end
      default:       begin src_idle_pct = 36; sink_stall_pct = 36; end
    endcase
  endfunction

  // one item beat; entered and left just after a falling edge
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] kidx,
                           input logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid     = 1'b1;
    item_bus.action    = act;
    item_bus.key_index = kidx;
    item_bus.byte_in   = data;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    if (act == ACT_LOAD) key_written[kidx] = 1'b1;
    @(negedge clk_i);
  endtask

  // fill any key byte the schedule would read unwritten, then restart
  task automatic restart_with_key();
    int unsigned period;
    if (cur_key_len == '0) period = 1;
    else if (int'(cur_key_len) > MAX_KEY_BYTES) period = MAX_KEY_BYTES;
    else period = int'(cur_key_len);
    for (int p = 0; p < int'(period); p++)
      if (!key_written[p]) send_item(ACT_LOAD, BYTE_W'(p), BYTE_W'($urandom));
    send_item(ACT_RESTART, BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  // drain results and let a trailing restart finish
  task automatic wait_idle();
    item_bus.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (RESTART_WAIT) @(negedge clk_i);
  endtask

  task automatic write_key_length(input logic [KLEN_W-1:0] len);
    cfg_bus.valid      = 1'b1;
    cfg_bus.key_length = len;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cur_key_len = len;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    int unsigned       sent;
    int unsigned       pick;
    logic [KLEN_W-1:0] phase_len;

    rst_ni             = 1'b0;
    item_bus.valid     = 1'b0;
    item_bus.action    = ACT_LOAD;
    item_bus.key_index = '0;
    item_bus.byte_in   = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.key_length = '0;
    hold_request       = 1'b0;
    cur_key_len        = KEY_LEN_RESET;
    set_idling(IDLE_NONE);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: key index extremes, unused action, reset key length
    send_item(ACT_LOAD, 8'd255, 8'h00);
    send_item(ACT_LOAD, 8'd0, 8'h00);
    send_item(ACT_LOAD, 8'd0, 8'hFF);
    send_item(ACT_UNUSED, 8'hFF, 8'hFF);
    restart_with_key();
    foreach (EDGE_BYTES[k]) send_item(ACT_DATA, 8'h00, EDGE_BYTES[k]);
    send_item(ACT_UNUSED, 8'h00, 8'h00);
    send_item(ACT_DATA, 8'hFF, 8'hFF);

    // directed: re-key in the middle of a stream
    restart_with_key();
    repeat (3) send_item(ACT_DATA, BYTE_W'($urandom), BYTE_W'($urandom));

    // directed: zero key length acts as one byte
    wait_idle();
    write_key_length('0);
    restart_with_key();
    repeat (3) send_item(ACT_DATA, BYTE_W'($urandom), BYTE_W'($urandom));

    // random phases, each with its own key length and idling pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       phase_len = KLEN_W'(MAX_KEY_BYTES);
        1:       phase_len = '1;
        2:       phase_len = KLEN_W'(MAX_KEY_BYTES + 1);
        3:       phase_len = KLEN_W'(2);
        4:       phase_len = '0;
        5:       phase_len = KLEN_W'($urandom_range(3, MAX_KEY_BYTES - 1));
        6:       phase_len = KLEN_W'($urandom_range(MAX_KEY_BYTES + 2, 510));
        default: phase_len = KLEN_W'(1);
      endcase
      wait_idle();
      write_key_length(phase_len);
      set_idling(idle_mode_e'(ph % 4));
      restart_with_key();

      // mostly data beats, with key rewrites, re-keys and unused actions
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          send_item(ACT_DATA, BYTE_W'($urandom), BYTE_W'($urandom));
          // hold-off starts once the key schedule is done and data flows
          if (ph == HOLD_PHASE) hold_request = 1'b1;
          sent++;
        end else if (pick < 90) begin
          send_item(ACT_LOAD, BYTE_W'($urandom), BYTE_W'($urandom));
          sent++;
        end else if (pick < 94) begin
          restart_with_key();
          sent++;
        end else begin
          send_item(ACT_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom));
        end
      end
    end

    // drain and verdict
    item_bus.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (RESTART_WAIT) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_chan_if.sv
hw/rtl/rc4_seq.sv
hw/rtl/rc4_stream_cipher.sv
test/rc4_stream_checker.sv
test/tb.sv
